@@ src/pid_controller_clamped_top_macros.svh @@
// Assertion macros used by the top-level module.
`ifndef PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH
// An implication checked on every rising clock edge outside reset.
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A next-cycle implication checked outside reset.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants and types for the clamped PID controller.
// ----------------------------------------------------------------------------
package pcc_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_PERIOD   = 3'd3;
    localparam logic [2:0] REG_RATE     = 3'd4;
    localparam logic [2:0] REG_INT_LIM  = 3'd5;
    localparam logic [2:0] REG_OUT_LIM  = 3'd6;

    // Handshake between the sequencer and the serial multiplier.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctrl;
endpackage

@@ src/pcc_serial_mul.sv @@
// ----------------------------------------------------------------------------
// pcc_serial_mul
// Bit-serial signed fixed-point multiplier with floor shift and saturation.
// ----------------------------------------------------------------------------
module pcc_serial_mul #(
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic                         o_busy,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_p
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_cnt;
    logic [DATA_WIDTH-1:0]   r_mcand;
    logic [DATA_WIDTH-1:0]   r_mplier;
    logic [PW-1:0]           r_acc;
    logic                    r_neg;
    logic                    r_done;
    logic signed [DATA_WIDTH-1:0] r_p;

    logic [PW-1:0]           n_acc;
    logic [PW-1:0]           w_q;
    logic                    w_frac;
    logic [PW-1:0]           w_mag;
    logic signed [DATA_WIDTH-1:0] w_res;

    // One multiplier bit per cycle: add the shifted multiplicand when set.
    always_comb begin
        n_acc = r_acc;
        if (r_mplier[0]) begin
            n_acc = r_acc + ({{DATA_WIDTH{1'b0}}, r_mcand} << r_cnt);
        end
    end

    // Magnitude shifted down, rounded to minus infinity for negatives.
    always_comb begin
        w_q    = r_acc >> FRAC_BITS;
        w_frac = |r_acc[FRAC_BITS-1:0];
        w_mag  = w_q + {{(PW-1){1'b0}}, (r_neg & w_frac)};
        if (!r_neg) begin
            if (w_mag > PW'({1'b0, {(DATA_WIDTH-1){1'b1}}}))
                w_res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            else
                w_res = w_mag[DATA_WIDTH-1:0];
        end else begin
            if (w_mag > PW'({1'b1, {(DATA_WIDTH-1){1'b0}}}))
                w_res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            else
                w_res = -w_mag[DATA_WIDTH-1:0];
        end
    end

    // Sequencer of the shift-and-add loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mcand  <= i_a[DATA_WIDTH-1] ? -i_a : i_a;
                        r_mplier <= i_b[DATA_WIDTH-1] ? -i_b : i_b;
                        r_neg    <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_acc    <= n_acc;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DATA_WIDTH - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_p     <= w_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

@@ src/pid_controller_clamped_top.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// Clamped PID controller with trapezoidal integral, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one transfer per control period, tdata
// holding error (low word) and error_rate (high word); the master channel
// then presents one transfer whose tdata is the clamped drive.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data;
// the user must write it while the block is idle, which it does not check.
// Sequence: four products, or five when the derivative comes from the
// internal difference, run one after another on one bit-serial multiplier;
// the integral is updated after the second product and the output is
// loaded after the last. One item at a time; tready rises again as the
// drive is loaded into the output register.
// While the receiver stalls the drive is held; the next item is accepted
// and worked on, and its drive waits until the output register is free.
// Reset (synchronous, active low) clears the configuration registers, the
// integral and both stored errors, and drops tvalid on the master side.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_top_macros.svh"
module pid_controller_clamped_top #(
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // tdata: error, error_rate
    input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: drive
    output logic [DATA_WIDTH-1:0]   m_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_addr,
    input  logic [DATA_WIDTH-1:0]   i_cfg_data
);
    localparam int W = DATA_WIDTH;
    typedef logic signed [W-1:0] t_val;
    localparam t_val VMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MW, S_WW, S_MS, S_WS, S_INT, S_MP, S_WP,
        S_ADDP, S_MD1, S_WD1, S_MD2, S_WD2, S_OUT, S_HOLD
    } t_state;

    // Saturating add at W bits.
    function automatic t_val sat_add(input t_val a, input t_val b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
        return s[W-1:0];
    endfunction

    function automatic t_val clamp(input t_val v, input logic [W-2:0] lim);
        t_val l;
        l = {1'b0, lim};
        if (lim == '0) return v;
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    t_val r_kp, r_ki, r_kd;
    logic [W-2:0] r_period, r_rate, r_ilim, r_olim;
    t_val r_isum, r_pwe, r_perr;
    t_val r_err, r_erate, r_we, r_acc, r_tmp;
    t_state r_state;
    logic r_ovalid;
    t_val r_drive;
    logic r_start;
    t_val r_ma, r_mb;

    pcc_pkg::t_mul_ctrl w_mul;
    t_val w_p;
    t_val w_mean;
    t_val w_diff;
    logic w_load;

    assign w_mul.start = r_start;

    pcc_serial_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul.start),
        .i_a(r_ma), .i_b(r_mb), .o_busy(w_mul.busy), .o_done(w_mul.done),
        .o_p(w_p)
    );

    // Floor mean of previous and current weighted error.
    always_comb begin
        logic signed [W:0] s;
        s      = {r_pwe[W-1], r_pwe} + {r_we[W-1], r_we};
        w_mean = s[W:1];
    end

    // Saturating error difference.
    always_comb begin
        logic signed [W:0] s;
        s = {r_err[W-1], r_err} - {r_perr[W-1], r_perr};
        if (s[W] != s[W-1]) w_diff = s[W] ? VMIN : VMAX;
        else w_diff = s[W-1:0];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_period <= '0; r_rate <= '0; r_ilim <= '0; r_olim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pcc_pkg::REG_GAIN_P:  r_kp     <= i_cfg_data;
                pcc_pkg::REG_GAIN_I:  r_ki     <= i_cfg_data;
                pcc_pkg::REG_GAIN_D:  r_kd     <= i_cfg_data;
                pcc_pkg::REG_PERIOD:  r_period <= i_cfg_data[W-2:0];
                pcc_pkg::REG_RATE:    r_rate   <= i_cfg_data[W-2:0];
                pcc_pkg::REG_INT_LIM: r_ilim   <= i_cfg_data[W-2:0];
                pcc_pkg::REG_OUT_LIM: r_olim   <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // The drive is loaded once the output register is empty or being read.
    assign w_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // Sequencer: each product is issued, then its result is awaited.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_isum   <= '0;
            r_pwe    <= '0;
            r_perr   <= '0;
        end else begin
            r_start  <= (r_state == S_MW) || (r_state == S_MS) || (r_state == S_MP) ||
                        (r_state == S_ADDP) || (r_state == S_MD2);
            r_ovalid <= w_load || (r_ovalid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err   <= s_axis_tdata[W-1:0];
                        r_erate <= s_axis_tdata[2*W-1:W];
                        r_state <= S_MW;
                    end
                end
                S_MW: begin
                    r_ma <= r_err; r_mb <= r_ki; r_state <= S_WW;
                end
                S_WW: if (w_mul.done) begin
                    r_we <= w_p; r_state <= S_MS;
                end
                S_MS: begin
                    r_ma <= w_mean; r_mb <= {1'b0, r_period};
                    r_state <= S_WS;
                end
                S_WS: if (w_mul.done) begin
                    r_tmp <= w_p; r_state <= S_INT;
                end
                S_INT: begin
                    r_pwe   <= r_we;
                    r_isum  <= clamp(sat_add(r_isum, r_tmp), r_ilim);
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_ma <= r_err; r_mb <= r_kp; r_state <= S_WP;
                end
                S_WP: if (w_mul.done) begin
                    r_acc <= sat_add(w_p, r_isum); r_state <= S_ADDP;
                end
                S_ADDP: begin
                    if (r_erate == '0) begin
                        r_ma <= w_diff; r_mb <= {1'b0, r_rate};
                        r_perr <= r_err;
                        r_state <= S_WD1;
                    end else begin
                        r_ma <= r_erate; r_mb <= r_kd;
                        r_state <= S_WD2;
                    end
                end
                S_WD1: if (w_mul.done) begin
                    r_tmp <= w_p; r_state <= S_MD2;
                end
                S_MD2: begin
                    r_ma <= r_kd; r_mb <= r_tmp; r_state <= S_WD2;
                end
                S_WD2: if (w_mul.done) begin
                    r_tmp <= clamp(sat_add(r_acc, w_p), r_olim); r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_drive  <= r_tmp;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_drive;

    `PCC_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, w_mul.start, !w_mul.busy,
        "multiplier started while busy")
    `PCC_ASSERT_IMP(a_done_wait, i_clk, i_rst_n, w_mul.done,
        r_state == S_WW || r_state == S_WS || r_state == S_WP ||
        r_state == S_WD1 || r_state == S_WD2, "product arrived unexpectedly")
    `PCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
